// ===== hdl/fupd_pkg.sv =====
// Shared types, character constants and the hex digit decoder for the
// form-urlencoded pair decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fupd_pkg;

  // Splitter position within the body (one-hot)
  typedef enum logic [3:0] {
    SPL_SKIP_AMP = 4'b0001,
    SPL_KEY      = 4'b0010,
    SPL_SKIP_EQ  = 4'b0100,
    SPL_VALUE    = 4'b1000
  } split_e;

  // Percent-escape progress (one-hot)
  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_HIGH = 3'b010,
    ESC_LOW  = 3'b100
  } esc_e;

  // Role of a result
  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR_END = 2'd2,
    KIND_BODY_END = 2'd3
  } kind_e;

  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChSpace = 8'h20;

  // Result queue geometry (power of two, room for two results per byte)
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       bad;
    logic       last;
  } result_t;

  // Results produced by one byte: up to two
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_t;

  // Hex digit value, either case; non-hex reads as zero and flags bad
  function automatic hex_t hex_nibble(logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.val = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.val = 4'(c[3:0] + 4'd9);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/form_urlencoded_pair_decoder_unit.sv =====
// Streaming form-urlencoded pair decoder: splitter, escape decoder and
// result queue. Depends on fupd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one raw body byte per cycle and emits decoded key/value bytes, pair
// end markers and a body-end marker, up to two results per byte. Each byte
// is decoded in the cycle it is transferred and its results are registered
// into a 4-entry result queue and delivered from its head in order. The
// input side takes a byte in every cycle in which the queue has room for two
// results; the output side delivers one result per cycle while out_ready_i
// is high, so a byte that causes two results takes two output transfers.
module form_urlencoded_pair_decoder_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] raw_byte_i,
  input  wire logic       body_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      decoded_byte_o,
  output logic            bad_escape_o,
  output logic            last_of_body_o
);

  localparam int unsigned PtrW = fupd_pkg::ResPtrW;
  localparam int unsigned CntW = fupd_pkg::ResCntW;

  // Append one result to the per-byte result pair
  function automatic fupd_pkg::res_pair_t add_res(fupd_pkg::res_pair_t a,
                                                  fupd_pkg::kind_e k,
                                                  logic [7:0] d, logic b);
    fupd_pkg::res_pair_t o;
    fupd_pkg::result_t   r;
    o      = a;
    r.kind = k;
    r.data = d;
    r.bad  = b;
    r.last = 1'b0;
    if (a.cnt == 2'd0) begin
      o.r0 = r;
    end else begin
      o.r1 = r;
    end
    o.cnt = a.cnt + 2'd1;
    return o;
  endfunction

  fupd_pkg::split_e    split_q, split_d;
  fupd_pkg::esc_e      esc_q, esc_d;
  logic [3:0]          hi_q, hi_d;
  logic                nerr_q, nerr_d;
  fupd_pkg::res_pair_t acc;

  fupd_pkg::result_t   fifo_q [fupd_pkg::ResDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [CntW-1:0]     cnt_q;
  logic [1:0]          push_n;
  logic                in_fire, pop;

  assign in_fire = in_valid_i & in_ready_o;
  assign pop     = out_valid_o & out_ready_i;

  // Per-byte decode: splitter step, escape step, end-of-body wrap-up
  always_comb begin
    fupd_pkg::hex_t  hx;
    fupd_pkg::kind_e pk;
    fupd_pkg::kind_e ek;
    logic            part_en, flush_en, pair_en, body_en;
    logic            is_amp, is_eq;

    split_d  = split_q;
    esc_d    = esc_q;
    hi_d     = hi_q;
    nerr_d   = nerr_q;
    acc      = '0;
    part_en  = 1'b0;
    flush_en = 1'b0;
    pair_en  = 1'b0;
    body_en  = 1'b0;
    pk       = fupd_pkg::KIND_KEY;
    ek       = fupd_pkg::KIND_KEY;
    hx       = fupd_pkg::hex_nibble(raw_byte_i);
    is_amp   = (raw_byte_i == fupd_pkg::ChAmp);
    is_eq    = (raw_byte_i == fupd_pkg::ChEq);

    // splitter
    case (split_q)
      fupd_pkg::SPL_SKIP_AMP: begin
        if (is_amp) begin
          body_en = body_end_i;
        end else if (is_eq) begin
          split_d = fupd_pkg::SPL_SKIP_EQ;
        end else begin
          split_d = fupd_pkg::SPL_KEY;
          part_en = 1'b1;
        end
      end
      fupd_pkg::SPL_KEY: begin
        if (is_eq) begin
          flush_en = 1'b1;
          split_d  = fupd_pkg::SPL_SKIP_EQ;
        end else begin
          part_en = 1'b1;
        end
      end
      fupd_pkg::SPL_SKIP_EQ: begin
        if (is_amp) begin
          pair_en = 1'b1;
          split_d = fupd_pkg::SPL_SKIP_AMP;
        end else if (!is_eq) begin
          split_d = fupd_pkg::SPL_VALUE;
          part_en = 1'b1;
          pk      = fupd_pkg::KIND_VALUE;
        end
      end
      fupd_pkg::SPL_VALUE: begin
        pk = fupd_pkg::KIND_VALUE;
        if (is_amp) begin
          flush_en = 1'b1;
          pair_en  = 1'b1;
          split_d  = fupd_pkg::SPL_SKIP_AMP;
        end else begin
          part_en = 1'b1;
        end
      end
      default: begin
        split_d = fupd_pkg::SPL_SKIP_AMP;
      end
    endcase

    // byte inside a key or value
    if (part_en) begin
      case (esc_q)
        fupd_pkg::ESC_HIGH: begin
          hi_d   = hx.val;
          nerr_d = hx.bad;
          esc_d  = fupd_pkg::ESC_LOW;
        end
        fupd_pkg::ESC_LOW: begin
          acc    = add_res(acc, pk, {hi_q, hx.val}, hx.bad | nerr_q);
          esc_d  = fupd_pkg::ESC_IDLE;
          hi_d   = 4'h0;
          nerr_d = 1'b0;
        end
        default: begin
          if (raw_byte_i == fupd_pkg::ChPct) begin
            esc_d = fupd_pkg::ESC_HIGH;
          end else if (raw_byte_i == fupd_pkg::ChPlus) begin
            acc = add_res(acc, pk, fupd_pkg::ChSpace, 1'b0);
          end else begin
            acc = add_res(acc, pk, raw_byte_i, 1'b0);
          end
        end
      endcase
    end

    // part closed by a separator: a pending escape yields a flagged byte
    if (flush_en) begin
      if (esc_q != fupd_pkg::ESC_IDLE) begin
        acc = add_res(acc, pk, (esc_q == fupd_pkg::ESC_LOW) ? {hi_q, 4'h0} : 8'h00,
                      1'b1);
      end
      esc_d  = fupd_pkg::ESC_IDLE;
      hi_d   = 4'h0;
      nerr_d = 1'b0;
    end

    if (pair_en) begin
      acc = add_res(acc, fupd_pkg::KIND_PAIR_END, 8'h00, 1'b0);
    end
    if (body_en) begin
      acc = add_res(acc, fupd_pkg::KIND_BODY_END, 8'h00, 1'b0);
    end

    // end of body: close an open pair, mark the last result, back to reset
    if (body_end_i) begin
      if (split_d != fupd_pkg::SPL_SKIP_AMP) begin
        if (split_d == fupd_pkg::SPL_KEY || split_d == fupd_pkg::SPL_VALUE) begin
          ek = (split_d == fupd_pkg::SPL_KEY) ? fupd_pkg::KIND_KEY
                                              : fupd_pkg::KIND_VALUE;
          if (esc_d != fupd_pkg::ESC_IDLE) begin
            acc = add_res(acc, ek,
                          (esc_d == fupd_pkg::ESC_LOW) ? {hi_d, 4'h0} : 8'h00, 1'b1);
          end
        end
        acc = add_res(acc, fupd_pkg::KIND_PAIR_END, 8'h00, 1'b0);
      end
      if (acc.cnt == 2'd1) begin
        acc.r0.last = 1'b1;
      end else if (acc.cnt == 2'd2) begin
        acc.r1.last = 1'b1;
      end
      split_d = fupd_pkg::SPL_SKIP_AMP;
      esc_d   = fupd_pkg::ESC_IDLE;
      hi_d    = 4'h0;
      nerr_d  = 1'b0;
    end
  end

  // Decoder state, advanced on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= fupd_pkg::SPL_SKIP_AMP;
      esc_q   <= fupd_pkg::ESC_IDLE;
      hi_q    <= 4'h0;
      nerr_q  <= 1'b0;
    end else if (in_fire) begin
      split_q <= split_d;
      esc_q   <= esc_d;
      hi_q    <= hi_d;
      nerr_q  <= nerr_d;
    end
  end

  // Result queue: up to two writes per byte, one read per cycle when the output is taken
  assign push_n    = in_fire ? acc.cnt : 2'd0;
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (in_fire && acc.cnt != 2'd0) begin
      fifo_q[wr_ptr_q] <= acc.r0;
    end
    if (in_fire && acc.cnt == 2'd2) begin
      fifo_q[wr_ptr_nx] <= acc.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_n) - CntW'(pop);
    end
  end

  // Handshake and result fields
  assign in_ready_o     = (cnt_q <= CntW'(fupd_pkg::ResDepth - 2));
  assign out_valid_o    = (cnt_q != '0);
  assign kind_o         = fifo_q[rd_ptr_q].kind;
  assign decoded_byte_o = fifo_q[rd_ptr_q].data;
  assign bad_escape_o   = fifo_q[rd_ptr_q].bad;
  assign last_of_body_o = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire

// ===== hdl/fupd_checker.sv =====
// Port-level checks for the form-urlencoded pair decoder, bound to its top
// level. Depends on fupd_pkg and form_urlencoded_pair_decoder_unit.
`timescale 1ns / 1ps
`default_nettype none

module fupd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [7:0] raw_byte_i,
  input wire logic       body_end_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] kind_o,
  input wire logic [7:0] decoded_byte_o,
  input wire logic       bad_escape_o,
  input wire logic       last_of_body_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(decoded_byte_o) && $stable(bad_escape_o) && $stable(last_of_body_o))
    else $error("result changed while stalled");

  // Markers carry no byte and no error
  a_marker_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == fupd_pkg::KIND_PAIR_END ||
                    kind_o == fupd_pkg::KIND_BODY_END)
      |-> decoded_byte_o == 8'h00 && !bad_escape_o)
    else $error("marker with data or error");

  // A body-end marker only closes a body
  a_body_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == fupd_pkg::KIND_BODY_END |-> last_of_body_o)
    else $error("body-end marker not last of body");

  // The last result of a body is always a marker
  a_last_is_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_body_o
      |-> kind_o == fupd_pkg::KIND_PAIR_END || kind_o == fupd_pkg::KIND_BODY_END)
    else $error("last result of body is a data byte");

  // A final body byte always leaves a result behind
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && body_end_i |=> out_valid_o)
    else $error("final byte produced no result");

endmodule

bind form_urlencoded_pair_decoder_unit fupd_checker u_fupd_checker (.*);

`default_nettype wire
